>>> sv/abl_pkg.sv
// Shared types and constants for the ambient backlight controller.
// No dependencies; imported by every module of the block.
package abl_pkg;

  localparam int unsigned LevelW   = 10;
  localparam int unsigned LumaW    = 8;
  localparam int unsigned ApbAddrW = 4;
  localparam int unsigned ApbDataW = 32;

  localparam logic [LevelW-1:0] LEVEL_MAX = 10'd1000;

  // Register reset values.
  localparam logic [LevelW-1:0] HYST_RESET    = 10'd50;
  localparam logic [LevelW-1:0] WALL_RESET    = 10'd600;
  localparam logic              PRESENT_RESET = 1'b1;

  // Register indexes, taken from paddr word bits.
  localparam logic [1:0] REG_HYST    = 2'd0;
  localparam logic [1:0] REG_WALL    = 2'd1;
  localparam logic [1:0] REG_PRESENT = 2'd2;

  typedef enum logic [1:0] {
    OP_LUMA   = 2'd0,
    OP_MANUAL = 2'd1,
    OP_RESUME = 2'd2,
    OP_POWER  = 2'd3
  } op_e;

  typedef struct packed {
    logic [LevelW-1:0] hyst;
    logic [LevelW-1:0] wall_level;
    logic              present;
  } cfg_t;

endpackage

>>> sv/abl_cfg.sv
// Configuration register file with an APB-style slave port.
// Depends on abl_pkg for the register map and the cfg_t struct.
module abl_cfg
  import abl_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_HYST:    cfg_d.hyst       = pwdata[LevelW-1:0];
        REG_WALL:    cfg_d.wall_level = pwdata[LevelW-1:0];
        REG_PRESENT: cfg_d.present    = pwdata[0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_HYST:    prdata = {{(ApbDataW-LevelW){1'b0}}, cfg_q.hyst};
      REG_WALL:    prdata = {{(ApbDataW-LevelW){1'b0}}, cfg_q.wall_level};
      REG_PRESENT: prdata = {{(ApbDataW-1){1'b0}}, cfg_q.present};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hyst       <= HYST_RESET;
      cfg_q.wall_level <= WALL_RESET;
      cfg_q.present    <= PRESENT_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> sv/abl_curve.sv
// Luma to backlight level map: flat ends, three linear ramps, truncation.
// Depends on abl_pkg; purely combinational, one shared multiplier.
module abl_curve
  import abl_pkg::*;
(
  input  logic [LumaW-1:0]  luma_i,
  output logic [LevelW-1:0] level_o
);

  // Each segment is base + (k * d) / div.  The division is a multiply by
  // ceil(2^18 / div) and a shift, exact for the small numerators used here.
  localparam int unsigned Shift = 18;

  logic [LumaW-1:0]  d;
  logic [11:0]       num;
  logic [16:0]       recip;
  logic [LevelW-1:0] base;
  logic              flat;
  logic [28:0]       prod;
  logic [10:0]       quot;

  always_comb begin
    d     = '0;
    num   = '0;
    recip = '0;
    base  = 10'd130;
    flat  = 1'b1;
    priority if (luma_i <= 8'd25) begin
      base = 10'd130;
    end else if (luma_i <= 8'd85) begin
      d     = luma_i - 8'd25;
      num   = {4'b0, d} * 12'd7;
      recip = 17'd43691;
      base  = 10'd130;
      flat  = 1'b0;
    end else if (luma_i <= 8'd150) begin
      d     = luma_i - 8'd85;
      num   = {4'b0, d} * 12'd20;
      recip = 17'd20165;
      base  = 10'd200;
      flat  = 1'b0;
    end else if (luma_i >= 8'd210) begin
      base = LEVEL_MAX;
    end else begin
      d     = luma_i - 8'd150;
      num   = {4'b0, d} * 12'd35;
      recip = 17'd87382;
      base  = 10'd300;
      flat  = 1'b0;
    end
  end

  assign prod = {17'b0, num} * {12'b0, recip};
  assign quot = prod[Shift+10:Shift];

  always_comb begin
    if (flat) begin
      level_o = base;
    end else begin
      level_o = base + quot[LevelW-1:0];
    end
  end

endmodule

>>> sv/abl_ctrl.sv
// Input register, control state, decision logic and result register.
// Depends on abl_pkg and instantiates abl_curve.
module abl_ctrl
  import abl_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        operation_i,
  input  logic [LumaW-1:0]  frame_luma_i,
  input  logic [LevelW-1:0] manual_level_i,
  input  logic              on_wall_power_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              drive_valid_o,
  output logic [LevelW-1:0] drive_level_o,
  output logic              sample_request_o,
  output logic              auto_active_o,
  output logic              wall_power_now_o,
  output logic [LumaW-1:0]  last_luma_o,
  output logic [LevelW-1:0] stored_manual_level_o
);

  // Input register.
  logic              in_vld_q;
  op_e               op_q;
  logic [LumaW-1:0]  luma_in_q;
  logic [LevelW-1:0] manual_in_q;
  logic              ac_in_q;

  // Control state.
  logic              auto_q, auto_d;
  logic              wall_q, wall_d;
  logic [LevelW-1:0] cur_q, cur_d;
  logic              known_q, known_d;
  logic [LumaW-1:0]  amb_q, amb_d;
  logic [LevelW-1:0] man_q, man_d;

  // Result register.
  logic              out_vld_q;
  logic              drive_q, drive_d;
  logic [LevelW-1:0] level_q, level_d;
  logic              sample_q, sample_d;

  logic              out_free;
  logic              advance;
  logic              accept;
  logic [LevelW-1:0] target;
  logic [LevelW-1:0] diff;
  logic [LevelW-1:0] wall_sat;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign advance    = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  abl_curve u_curve (
    .luma_i  (luma_in_q),
    .level_o (target)
  );

  assign diff     = (target >= cur_q) ? (target - cur_q) : (cur_q - target);
  assign wall_sat = (cfg_i.wall_level > LEVEL_MAX) ? LEVEL_MAX : cfg_i.wall_level;

  always_comb begin
    auto_d   = auto_q;
    wall_d   = wall_q;
    cur_d    = cur_q;
    known_d  = known_q;
    amb_d    = amb_q;
    man_d    = man_q;
    drive_d  = 1'b0;
    level_d  = '0;
    sample_d = 1'b0;
    unique case (op_q)
      OP_LUMA: begin
        amb_d = luma_in_q;
        if (auto_q && !wall_q && cfg_i.present && (!known_q || diff >= cfg_i.hyst)) begin
          drive_d = 1'b1;
          level_d = target;
        end
      end
      OP_MANUAL: begin
        auto_d = 1'b0;
        if (manual_in_q <= LEVEL_MAX) begin
          man_d = manual_in_q;
        end
      end
      OP_RESUME: begin
        auto_d   = 1'b1;
        sample_d = 1'b1;
      end
      OP_POWER: begin
        if (ac_in_q != wall_q) begin
          wall_d = ac_in_q;
          if (ac_in_q) begin
            if (cfg_i.present) begin
              drive_d = 1'b1;
              level_d = wall_sat;
            end
          end else if (auto_q) begin
            // Unplugged in auto mode: ask for a fresh frame.
            sample_d = 1'b1;
          end
        end
      end
      default: begin
        auto_d = auto_q;
      end
    endcase
    if (drive_d) begin
      cur_d   = level_d;
      known_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      auto_q    <= 1'b1;
      wall_q    <= 1'b0;
      cur_q     <= '0;
      known_q   <= 1'b0;
      amb_q     <= '0;
      man_q     <= '0;
    end else begin
      if (accept) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        auto_q    <= auto_d;
        wall_q    <= wall_d;
        cur_q     <= cur_d;
        known_q   <= known_d;
        amb_q     <= amb_d;
        man_q     <= man_d;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q        <= op_e'(operation_i);
      luma_in_q   <= frame_luma_i;
      manual_in_q <= manual_level_i;
      ac_in_q     <= on_wall_power_i;
    end
    if (advance) begin
      drive_q               <= drive_d;
      level_q               <= level_d;
      sample_q              <= sample_d;
      auto_active_o         <= auto_d;
      wall_power_now_o      <= wall_d;
      last_luma_o           <= amb_d;
      stored_manual_level_o <= man_d;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign drive_valid_o    = drive_q;
  assign drive_level_o    = level_q;
  assign sample_request_o = sample_q;

endmodule

>>> sv/ambient_backlight_controller.sv
// Top level of the ambient backlight controller.
// Depends on abl_pkg, abl_cfg, abl_curve and abl_ctrl.
//
//   Port group  | Direction | Handshake              | Word contents
//   ------------+-----------+------------------------+------------------------------
//   in          | in        | in_valid_i/in_stall_o  | operation, luma, manual, power
//   out         | out       | out_valid_o/out_stall_i| drive, level, sample, status
//   apb         | in        | psel/penable, pready=1 | three config registers
//
// Every word gives exactly one result word. A word is held in the
// input register, and then the decision logic (the luma curve with one
// shared multiplier) feeds the result register; one word can be taken
// every cycle while out_stall_i is low. Reset clears both valid flags and
// the control state but sets auto mode. The result register holds while
// out_stall_i is high; the input register still takes a word then, and
// in_stall_o rises only when both registers are full.
module ambient_backlight_controller
  import abl_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          operation_i,
  input  logic [LumaW-1:0]    frame_luma_i,
  input  logic [LevelW-1:0]   manual_level_i,
  input  logic                on_wall_power_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                drive_valid_o,
  output logic [LevelW-1:0]   drive_level_o,
  output logic                sample_request_o,
  output logic                auto_active_o,
  output logic                wall_power_now_o,
  output logic [LumaW-1:0]    last_luma_o,
  output logic [LevelW-1:0]   stored_manual_level_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  cfg_t cfg;

  abl_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  abl_ctrl u_ctrl (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_i                 (cfg),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .operation_i           (operation_i),
    .frame_luma_i          (frame_luma_i),
    .manual_level_i        (manual_level_i),
    .on_wall_power_i       (on_wall_power_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .drive_valid_o         (drive_valid_o),
    .drive_level_o         (drive_level_o),
    .sample_request_o      (sample_request_o),
    .auto_active_o         (auto_active_o),
    .wall_power_now_o      (wall_power_now_o),
    .last_luma_o           (last_luma_o),
    .stored_manual_level_o (stored_manual_level_o)
  );

endmodule

>>> sv/abl_checker.sv
// Port-level checks for the ambient backlight controller, bound to the top.
// Depends on abl_pkg for the level limit.
module abl_checker
  import abl_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic              drive_valid_o,
  input logic [LevelW-1:0] drive_level_o,
  input logic              sample_request_o
);

  // A stalled result word stays presented.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(drive_level_o))
    else $error("result word dropped or changed while stalled");

  // No level is reported unless a level is driven.
  a_level_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !drive_valid_o |-> drive_level_o == '0)
    else $error("level reported without a drive");

  // Driven levels never exceed full scale.
  a_level_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && drive_valid_o |-> drive_level_o <= LEVEL_MAX)
    else $error("driven level above full scale");

  // No operation both drives a level and asks for a frame.
  a_drive_xor_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(drive_valid_o && sample_request_o))
    else $error("drive and sample request in the same word");

endmodule

bind ambient_backlight_controller abl_checker u_abl_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .drive_valid_o    (drive_valid_o),
  .drive_level_o    (drive_level_o),
  .sample_request_o (sample_request_o)
);
